### rtl/core/sttb_pkg.sv
package sttb_pkg;

    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int ROW_IN_W   = 5;
    localparam int COL_IN_W   = 7;
    localparam int POS_OUT_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0]  SPACE_CHAR = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_FG   = 8'd7;
    localparam logic [COLOR_W-1:0] RESET_BG   = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;

    typedef enum logic [1:0] {
        CMD_WRITE     = 2'd0,
        CMD_PAD       = 2'd1,
        CMD_BACKSPACE = 2'd2,
        CMD_READ      = 2'd3
    } sttb_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GLYPH,
        ST_SCROLL,
        ST_STEP,
        ST_REDUCE,
        ST_SUM,
        ST_RESP
    } sttb_state_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } sttb_cell_t;

    typedef struct packed {
        sttb_cmd_t           command;
        logic [CHAR_W-1:0]   character;
        logic [ROW_IN_W-1:0] cell_row;
        logic [COL_IN_W-1:0] cell_column;
    } sttb_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [COLOR_W-1:0]   cell_fg;
        logic [COLOR_W-1:0]   cell_bg;
        logic [POS_OUT_W-1:0] cursor_position;
        logic [POS_OUT_W-1:0] top_position;
        logic                 scrolled;
    } sttb_out_t;

endpackage

### rtl/core/sttb_cell_ram.sv
module sttb_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  sttb_pkg::sttb_cell_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output sttb_pkg::sttb_cell_t rdata
);

    sttb_pkg::sttb_cell_t mem [DEPTH];
    sttb_pkg::sttb_cell_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // The read data holds until the next read, so a stalled result stays intact.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

    a_no_read_write_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        re |-> !we)
        else $error("cell memory read and written in the same cycle");

endmodule

### rtl/core/sttb_offset_mod.sv
module sttb_offset_mod #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [sttb_pkg::ROW_IN_W-1:0]         row,
    input  logic [sttb_pkg::COL_IN_W-1:0]         col,
    output logic                                  done,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       rem
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int PW    = $clog2(CELL_COUNT);
    // Wide enough for the largest offset and for the ring length itself.
    localparam int OFF_W = $clog2(32 * COLUMNS + 128 + CELL_COUNT);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [OFF_W-1:0] rem_reg, rem_next;
    logic             fits;

    assign fits = (rem_reg < OFF_W'(CELL_COUNT));

    // The offset is brought into the ring by taking off one ring length per cycle;
    // with the default size at most one is ever needed.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            rem_next  = OFF_W'(row) * OFF_W'(COLUMNS) + OFF_W'(col);
        end else if (busy_reg) begin
            if (fits) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                rem_next = rem_reg - OFF_W'(CELL_COUNT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = PW'(rem_reg);

    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < OFF_W'(CELL_COUNT)))
        else $error("offset remainder not below the cell count");

endmodule

### rtl/core/scrolling_text_terminal_buffer.sv
// Write and backspace: the word passes through ST_GLYPH, ST_STEP and ST_RESP; the next word
// is taken only back in ST_IDLE. A scroll adds one memory write per cell of the cleared row.
// Pad line: one ST_GLYPH and ST_STEP pass per space written, plus a row clear if it scrolls.
// Read cell: the offset is first brought into the ring (at most one ring length taken off
// at the default size), then the cell is read. After reset the cell memory is cleared one
// cell per cycle with s_ready low; configuration writes are taken throughout.
module scrolling_text_terminal_buffer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  sttb_pkg::sttb_in_t                   s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sttb_pkg::sttb_out_t                  m_payload,
    input  logic                                 cfg_wr_en,
    input  logic [sttb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sttb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int PW  = $clog2(CELL_COUNT);
    localparam int CW  = $clog2(COLUMNS);
    localparam int PCW = $clog2(COLUMNS + 1);

    sttb_pkg::sttb_state_t state_reg, state_next;

    logic [PW-1:0]  init_cnt_reg, init_cnt_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [CW-1:0]  wcol_reg, wcol_next;
    logic [PW-1:0]  top_reg, top_next;
    sttb_pkg::sttb_cmd_t cmd_reg, cmd_next;
    logic [sttb_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [PCW-1:0] pad_cnt_reg, pad_cnt_next;
    logic [CW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic           scrolled_reg, scrolled_next;
    logic [sttb_pkg::COLOR_W-1:0] fg_reg, fg_next;
    logic [sttb_pkg::COLOR_W-1:0] bg_reg, bg_next;
    logic           m_valid_reg, m_valid_next;
    sttb_pkg::sttb_out_t m_payload_reg, m_payload_next;

    logic           accept;
    logic           out_free;
    logic [PW-1:0]  wp_inc, wp_dec, top_inc;
    logic [CW-1:0]  wcol_inc, wcol_dec;
    logic [PW:0]    read_sum;
    logic [PW-1:0]  read_addr;

    logic                 ram_we, ram_re;
    logic [PW-1:0]        ram_waddr, ram_raddr;
    sttb_pkg::sttb_cell_t ram_wdata, ram_rdata;

    logic           mod_start, mod_done;
    logic [PW-1:0]  mod_rem;

    sttb_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (PW)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr   (ram_raddr),
        .rdata   (ram_rdata)
    );

    sttb_offset_mod #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .row     (s_payload.cell_row),
        .col     (s_payload.cell_column),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign wp_inc   = (wp_reg == PW'(CELL_COUNT - 1)) ? '0 : wp_reg + PW'(1);
    assign wp_dec   = (wp_reg == '0) ? PW'(CELL_COUNT - 1) : wp_reg - PW'(1);
    assign wcol_inc = (wcol_reg == CW'(COLUMNS - 1)) ? '0 : wcol_reg + CW'(1);
    assign wcol_dec = (wcol_reg == '0) ? CW'(COLUMNS - 1) : wcol_reg - CW'(1);
    // The top line always sits on a row boundary.
    assign top_inc  = (top_reg == PW'(CELL_COUNT - COLUMNS)) ? '0 : top_reg + PW'(COLUMNS);

    assign read_sum  = {1'b0, top_reg} + {1'b0, mod_rem};
    assign read_addr = (read_sum >= (PW+1)'(CELL_COUNT)) ?
                       PW'(read_sum - (PW+1)'(CELL_COUNT)) : PW'(read_sum);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sttb_pkg::ST_CLEAR: begin
                if (init_cnt_reg == PW'(CELL_COUNT - 1)) begin
                    state_next = sttb_pkg::ST_IDLE;
                end
            end
            sttb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_payload.command == sttb_pkg::CMD_READ) begin
                        state_next = sttb_pkg::ST_REDUCE;
                    end else begin
                        state_next = sttb_pkg::ST_GLYPH;
                    end
                end
            end
            sttb_pkg::ST_GLYPH: begin
                if (wp_inc == top_reg) begin
                    state_next = sttb_pkg::ST_SCROLL;
                end else begin
                    state_next = sttb_pkg::ST_STEP;
                end
            end
            sttb_pkg::ST_SCROLL: begin
                if (clr_cnt_reg == CW'(COLUMNS - 1)) begin
                    state_next = sttb_pkg::ST_STEP;
                end
            end
            sttb_pkg::ST_STEP: begin
                if (cmd_reg == sttb_pkg::CMD_PAD && pad_cnt_reg != PCW'(1)) begin
                    state_next = sttb_pkg::ST_GLYPH;
                end else begin
                    state_next = sttb_pkg::ST_RESP;
                end
            end
            sttb_pkg::ST_REDUCE: begin
                if (mod_done) begin
                    state_next = sttb_pkg::ST_SUM;
                end
            end
            sttb_pkg::ST_SUM: begin
                state_next = sttb_pkg::ST_RESP;
            end
            sttb_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = sttb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sttb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs towards the memory, the modulo unit and the input channel.
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = '{char_code: sttb_pkg::SPACE_CHAR, fg: fg_reg, bg: bg_reg};
        ram_re    = 1'b0;
        ram_raddr = read_addr;
        mod_start = 1'b0;
        case (state_reg)
            sttb_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = '{char_code: sttb_pkg::SPACE_CHAR,
                              fg: sttb_pkg::RESET_FG, bg: sttb_pkg::RESET_BG};
            end
            sttb_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mod_start = s_valid && (s_payload.command == sttb_pkg::CMD_READ);
            end
            sttb_pkg::ST_GLYPH: begin
                ram_we    = 1'b1;
                ram_waddr = wp_reg;
                if (cmd_reg == sttb_pkg::CMD_WRITE) begin
                    ram_wdata.char_code = char_reg;
                end
            end
            sttb_pkg::ST_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = top_reg + PW'(clr_cnt_reg);
            end
            sttb_pkg::ST_SUM: begin
                ram_re = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        init_cnt_next  = init_cnt_reg;
        wp_next        = wp_reg;
        wcol_next      = wcol_reg;
        top_next       = top_reg;
        cmd_next       = cmd_reg;
        char_next      = char_reg;
        pad_cnt_next   = pad_cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        scrolled_next  = scrolled_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        if (cfg_wr_en) begin
            if (cfg_index == sttb_pkg::CFG_FOREGROUND) begin
                fg_next = cfg_wdata;
            end else if (cfg_index == sttb_pkg::CFG_BACKGROUND) begin
                bg_next = cfg_wdata;
            end
        end

        case (state_reg)
            sttb_pkg::ST_CLEAR: begin
                init_cnt_next = init_cnt_reg + PW'(1);
            end
            sttb_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next      = s_payload.command;
                    char_next     = s_payload.character;
                    scrolled_next = 1'b0;
                    pad_cnt_next  = PCW'(COLUMNS) - PCW'(wcol_reg);
                    // Backspace steps back first; the blank then lands behind the cursor.
                    if (s_payload.command == sttb_pkg::CMD_BACKSPACE) begin
                        wp_next   = wp_dec;
                        wcol_next = wcol_dec;
                    end
                end
            end
            sttb_pkg::ST_GLYPH: begin
                wp_next      = wp_inc;
                wcol_next    = wcol_inc;
                clr_cnt_next = '0;
            end
            sttb_pkg::ST_SCROLL: begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(COLUMNS - 1)) begin
                    top_next      = top_inc;
                    scrolled_next = 1'b1;
                end
            end
            sttb_pkg::ST_STEP: begin
                if (cmd_reg == sttb_pkg::CMD_PAD) begin
                    pad_cnt_next = pad_cnt_reg - PCW'(1);
                end
                if (cmd_reg == sttb_pkg::CMD_BACKSPACE) begin
                    wp_next   = wp_dec;
                    wcol_next = wcol_dec;
                end
            end
            sttb_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next                   = 1'b1;
                    m_payload_next.cursor_position = sttb_pkg::POS_OUT_W'(wp_reg);
                    m_payload_next.top_position    = sttb_pkg::POS_OUT_W'(top_reg);
                    m_payload_next.scrolled        = scrolled_reg;
                    if (cmd_reg == sttb_pkg::CMD_READ) begin
                        m_payload_next.cell_char = ram_rdata.char_code;
                        m_payload_next.cell_fg   = ram_rdata.fg;
                        m_payload_next.cell_bg   = ram_rdata.bg;
                    end else begin
                        m_payload_next.cell_char = '0;
                        m_payload_next.cell_fg   = '0;
                        m_payload_next.cell_bg   = '0;
                    end
                end
            end
            default: begin
                init_cnt_next = init_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sttb_pkg::ST_CLEAR;
            init_cnt_reg <= '0;
            wp_reg       <= '0;
            wcol_reg     <= '0;
            top_reg      <= '0;
            fg_reg       <= sttb_pkg::RESET_FG;
            bg_reg       <= sttb_pkg::RESET_BG;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            wp_reg       <= wp_next;
            wcol_reg     <= wcol_next;
            top_reg      <= top_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        char_reg      <= char_next;
        pad_cnt_reg   <= pad_cnt_next;
        clr_cnt_reg   <= clr_cnt_next;
        scrolled_reg  <= scrolled_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_positions_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (wp_reg < PW'(CELL_COUNT)) && (top_reg < PW'(CELL_COUNT)))
        else $error("cursor or top line outside the ring");

    a_scroll_on_top_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sttb_pkg::ST_GLYPH && wp_inc == top_reg)
        |=> (state_reg == sttb_pkg::ST_SCROLL && clr_cnt_reg == '0))
        else $error("cursor reached the top line without a row clear");

    a_no_write_while_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sttb_pkg::ST_REDUCE || state_reg == sttb_pkg::ST_SUM) |-> !ram_we)
        else $error("cell memory written during a read");

endmodule
